// ===== rtl/core/ttn_pkg.sv =====
// ----------------------------------------------------------------------------
// ttn_pkg
// shared types and constants for the tick to ntp timestamp core
// ----------------------------------------------------------------------------
`default_nettype none

package ttn_pkg;

    localparam int TICK_W  = 64;   // tick counter width
    localparam int SECS_W  = 32;   // ntp seconds width
    localparam int FRAC_W  = 32;   // ntp fraction width
    localparam int FREQ_W  = 32;   // tick frequency width
    localparam int CFG_W   = 64;   // widest configuration register
    localparam int CFG_IDX_W = 2;

    // quotient bits kept: low seconds bits and the fraction
    localparam int QUOT_W  = SECS_W + FRAC_W;
    // total dividend bits walked: elapsed ticks then fraction zeros
    localparam int DIV_STEPS = TICK_W + FRAC_W;

    localparam int STEPS_PER_STAGE_DEF = 4;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_FREQ  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SECS  = 2'd2;

    localparam logic [FREQ_W-1:0] TICK_FREQ_RESET = 32'd1000000;
    localparam logic [SECS_W-1:0] NTP_UNIX_OFFSET = 32'd2208988800;

    // partial division state carried down the pipeline
    typedef struct packed {
        logic [FREQ_W-1:0] rem;    // running remainder, always below the divisor
        logic [TICK_W-1:0] dvd;    // dividend bits still to shift in, msb first
        logic [QUOT_W-1:0] quot;   // quotient bits collected so far
    } div_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/ttn_ifs.sv =====
// ----------------------------------------------------------------------------
// ttn request channels
// valid/ready channels for tick counts in and timestamps out
// ----------------------------------------------------------------------------
`default_nettype none

interface ttn_tick_if
    import ttn_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] now_ticks;

    modport source (output valid, output now_ticks, input ready);
    modport sink   (input valid, input now_ticks, output ready);
endinterface

interface ttn_stamp_if
    import ttn_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [SECS_W-1:0] ntp_seconds;
    logic [FRAC_W-1:0] ntp_fraction;

    modport source (output valid, output ntp_seconds, output ntp_fraction, input ready);
    modport sink   (input valid, input ntp_seconds, input ntp_fraction, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ttn_div_stage.sv =====
// ----------------------------------------------------------------------------
// ttn_div_stage
// one registered slice of the restoring divider, STEPS quotient bits per slice
// ----------------------------------------------------------------------------
`default_nettype none

module ttn_div_stage
    import ttn_pkg::*;
#(
    parameter int STEPS = STEPS_PER_STAGE_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic [FREQ_W-1:0] divisor,
    input  wire logic              prev_valid,
    input  wire div_state_t        prev_state,
    output logic                   stage_valid,
    output div_state_t             stage_state
);

    logic       valid_reg;
    div_state_t state_reg;
    div_state_t state_next;

    always_comb
    begin
        logic [FREQ_W:0] trial;
        logic [FREQ_W:0] diff;
        state_next = prev_state;
        for (int i = 0; i < STEPS; i++)
        begin
            trial = {state_next.rem, state_next.dvd[TICK_W-1]};
            diff  = trial - {1'b0, divisor};
            state_next.dvd = {state_next.dvd[TICK_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                state_next.rem  = diff[FREQ_W-1:0];
                state_next.quot = {state_next.quot[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                state_next.rem  = trial[FREQ_W-1:0];
                state_next.quot = {state_next.quot[QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_state = state_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tick_to_ntp_timestamp_core.sv =====
// ----------------------------------------------------------------------------
// tick_to_ntp_timestamp_core
// converts a free-running tick count into a 64-bit ntp timestamp
// ----------------------------------------------------------------------------
//
//  channel   kind          payload
//  --------  ------------  ------------------------------------------------
//  tick      request in    now_ticks (64)
//  stamp     request out   ntp_seconds (32), ntp_fraction (32)
//  cfg_*     write port    cfg_index (2), cfg_data (64), no read-back
//
//  one request enters per cycle while the spare output entry is empty; a request
//  passes the entry slice, the divider slices and the output register, and the
//  restoring divider retires STEPS_PER_STAGE quotient bits per pipeline slice
//  rst_n clears the valid bits and loads the register reset values
//  a stall on stamp is absorbed by a two-entry output buffer; the pipeline
//  freezes only while the spare entry is occupied, nothing lost or repeated
// ----------------------------------------------------------------------------
`default_nettype none

module tick_to_ntp_timestamp_core
    import ttn_pkg::*;
#(
    parameter int STEPS_PER_STAGE = STEPS_PER_STAGE_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    ttn_tick_if.sink                  tick,
    ttn_stamp_if.source               stamp,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int NUM_STAGES = DIV_STEPS / STEPS_PER_STAGE;

    // configuration registers; a zero frequency is stored as one
    logic [TICK_W-1:0] base_ticks_reg;
    logic [FREQ_W-1:0] divisor_reg;
    logic [SECS_W-1:0] base_secs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_ticks_reg <= '0;
            divisor_reg    <= TICK_FREQ_RESET;
            base_secs_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_TICKS:
                begin
                    base_ticks_reg <= cfg_data;
                end
                REG_TICK_FREQ:
                begin
                    if (cfg_data[FREQ_W-1:0] == '0)
                    begin
                        divisor_reg <= {{(FREQ_W-1){1'b0}}, 1'b1};
                    end
                    else
                    begin
                        divisor_reg <= cfg_data[FREQ_W-1:0];
                    end
                end
                REG_BASE_SECS:
                begin
                    base_secs_reg <= cfg_data[SECS_W-1:0];
                end
                default:
                begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // whole pipeline moves together unless the output spare entry is full
    logic advance;
    logic skid_valid_reg;

    assign advance    = !skid_valid_reg;
    assign tick.ready = advance;

    // entry slice: elapsed ticks, wrapping modulo 2^64
    logic       valid0_reg;
    div_state_t state0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid0_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state0_reg.rem  <= '0;
            state0_reg.dvd  <= tick.now_ticks - base_ticks_reg;
            state0_reg.quot <= '0;
        end
    end

    // divider slices; the dividend shifts out msb first and zeros follow,
    // so the last 32 quotient bits are the binary fraction
    logic       pipe_valid [NUM_STAGES+1];
    div_state_t pipe_state [NUM_STAGES+1];

    assign pipe_valid[0] = valid0_reg;
    assign pipe_state[0] = state0_reg;

    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_div
        ttn_div_stage #(
            .STEPS (STEPS_PER_STAGE)
        ) u_stage (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (advance),
            .divisor     (divisor_reg),
            .prev_valid  (pipe_valid[g]),
            .prev_state  (pipe_state[g]),
            .stage_valid (pipe_valid[g+1]),
            .stage_state (pipe_state[g+1])
        );
    end

    // seconds: low quotient word plus base seconds and the 1900 epoch offset
    logic              last_valid;
    logic [SECS_W-1:0] last_secs;
    logic [FRAC_W-1:0] last_frac;

    assign last_valid = pipe_valid[NUM_STAGES];
    assign last_secs  = pipe_state[NUM_STAGES].quot[QUOT_W-1:FRAC_W]
                        + base_secs_reg + NTP_UNIX_OFFSET;
    assign last_frac  = pipe_state[NUM_STAGES].quot[FRAC_W-1:0];

    // output register plus spare entry
    logic              out_valid_reg;
    logic [SECS_W-1:0] out_secs_reg;
    logic [FRAC_W-1:0] out_frac_reg;
    logic [SECS_W-1:0] skid_secs_reg;
    logic [FRAC_W-1:0] skid_frac_reg;
    logic              push;
    logic              out_free;

    assign push     = advance && last_valid;
    assign out_free = !out_valid_reg || stamp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (stamp.ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (out_free)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (stamp.ready)
            begin
                out_secs_reg <= skid_secs_reg;
                out_frac_reg <= skid_frac_reg;
            end
        end
        else if (out_free)
        begin
            out_secs_reg <= last_secs;
            out_frac_reg <= last_frac;
        end
        else
        begin
            skid_secs_reg <= last_secs;
            skid_frac_reg <= last_frac;
        end
    end

    assign stamp.valid        = out_valid_reg;
    assign stamp.ntp_seconds  = out_secs_reg;
    assign stamp.ntp_fraction = out_frac_reg;

`ifndef ASSERT_OFF
    // spare entry only ever holds a request behind a waiting output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("spare entry full with output register empty");

    // spare entry fills only when the output was stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !stamp.ready && last_valid))
        else $error("spare entry filled without a stalled output");

    // a taken output with a full spare entry drains it next cycle
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && stamp.ready) |=> (!skid_valid_reg && out_valid_reg))
        else $error("spare entry not drained into the output register");

    // divisor never reaches zero, whatever gets written
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        divisor_reg != '0)
        else $error("divisor register holds zero");
`endif

endmodule

`default_nettype wire

// ===== verif/tick_to_ntp_timestamp_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_to_ntp_timestamp_core_tb
// self-checking bench: tick counts go in on the tick channel, every timestamp
// on the stamp channel is compared with a local predictor in arrival order,
// under several register settings and random flow control on both channels
// ----------------------------------------------------------------------------

module tick_to_ntp_timestamp_core_tb;
    import ttn_pkg::*;

    // index 3 decodes to no register, so writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int RANDOM_PHASES    = 8;
    localparam int REQS_PER_PHASE   = 144;
    localparam int DRAIN_TAIL       = 40;       // a little over the pipeline depth

    typedef struct packed {
        logic [SECS_W-1:0] secs;
        logic [FRAC_W-1:0] frac;
    } ntp_stamp_t;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of the registers, expected timestamps in order
    // ------------------------------------------------------------------------
    class stamp_scoreboard;
        logic [TICK_W-1:0] base_ticks;
        logic [FREQ_W-1:0] tick_freq;
        logic [SECS_W-1:0] base_secs;
        ntp_stamp_t        expected_stamps[$];
        int                mismatches;
        int                requests_seen;
        int                stamps_checked;

        function new();
            base_ticks     = '0;
            tick_freq      = TICK_FREQ_RESET;
            base_secs      = '0;
            mismatches     = 0;
            requests_seen  = 0;
            stamps_checked = 0;
        endfunction

        // mirror of a register write; the unused index is dropped
        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_BASE_TICKS: base_ticks = data;
                REG_TICK_FREQ:  tick_freq  = data[FREQ_W-1:0];
                REG_BASE_SECS:  base_secs  = data[SECS_W-1:0];
                default: ;
            endcase
        endfunction

        function ntp_stamp_t ntp_from_ticks(logic [TICK_W-1:0] now);
            logic [63:0] divisor;
            logic [63:0] elapsed;
            logic [63:0] whole;
            logic [63:0] leftover;
            logic [63:0] frac_wide;
            ntp_stamp_t  stamp;
            // a zero frequency behaves as one tick per second
            divisor   = (tick_freq == '0) ? 64'd1 : {32'd0, tick_freq};
            elapsed   = now - base_ticks;          // wraps when the counter is behind
            whole     = elapsed / divisor;
            leftover  = elapsed % divisor;         // below 2^32, so the shift fits
            frac_wide = {leftover[31:0], 32'd0} / divisor;
            stamp.secs = whole[SECS_W-1:0] + base_secs + NTP_UNIX_OFFSET;
            stamp.frac = frac_wide[FRAC_W-1:0];
            return stamp;
        endfunction

        function void note_request(logic [TICK_W-1:0] now);
            expected_stamps.push_back(ntp_from_ticks(now));
            requests_seen++;
        endfunction

        function int pending();
            return expected_stamps.size();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH %s", $time, what);
            mismatches++;
        endtask

        task check_stamp(logic [SECS_W-1:0] secs, logic [FRAC_W-1:0] frac);
            ntp_stamp_t exp_stamp;
            if (expected_stamps.size() == 0)
            begin
                report_mismatch($sformatf("unexpected stamp secs=%h frac=%h", secs, frac));
            end
            else
            begin
                exp_stamp = expected_stamps.pop_front();
                stamps_checked++;
                if (secs !== exp_stamp.secs)
                    report_mismatch($sformatf("ntp_seconds got %h want %h",
                                              secs, exp_stamp.secs));
                if (frac !== exp_stamp.frac)
                    report_mismatch($sformatf("ntp_fraction got %h want %h",
                                              frac, exp_stamp.frac));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, channels and the block
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int send_idle_pct;
    int recv_idle_pct;

    stamp_scoreboard stamps = new();

    ttn_tick_if  tick_ch ();
    ttn_stamp_if stamp_ch ();

    tick_to_ntp_timestamp_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .stamp     (stamp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: ready changes on the falling edge, stalls at the current rate
    initial
    begin
        stamp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stamp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // every stamp taken at a rising edge goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && stamp_ch.valid && stamp_ch.ready)
            stamps.check_stamp(stamp_ch.ntp_seconds, stamp_ch.ntp_fraction);
    end

    // ------------------------------------------------------------------------
    // drivers, all entered and left at a falling edge
    // ------------------------------------------------------------------------

    // one register write; the caller lowers the write enable after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        stamps.apply_write(idx, data);
        @(negedge clk);
    endtask

    // loads all three registers, plus a stray write to the unused index;
    // junk in the upper data bits checks that narrow registers truncate
    task automatic load_config(input logic [TICK_W-1:0] base,
                               input logic [FREQ_W-1:0] freq,
                               input logic [SECS_W-1:0] secs);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        write_reg(REG_BASE_TICKS, base);
        write_reg(REG_TICK_FREQ, {$urandom, freq});
        write_reg(REG_BASE_SECS, {$urandom, secs});
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // presents one tick count and holds it until the block takes it;
    // valid stays high straight into the next request when no gap is drawn
    task automatic send_tick(input logic [TICK_W-1:0] ticks);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tick_ch.valid     <= 1'b1;
        tick_ch.now_ticks <= ticks;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        stamps.note_request(ticks);
        @(negedge clk);
    endtask

    // sender goes quiet until every outstanding stamp is back
    task automatic drain_stamps();
        tick_ch.valid <= 1'b0;
        @(negedge clk);
        while (stamps.pending() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // random picks, biased towards the interesting corners
    // ------------------------------------------------------------------------
    function automatic logic [FREQ_W-1:0] pick_freq();
        case ($urandom_range(0, 7))
            0:       return '0;             // treated as 1 Hz
            1:       return 32'd1;
            2:       return '1;             // largest divisor
            3:       return 32'd1000000;
            4:       return 32'd32768;
            5:       return 32'd1000000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [TICK_W-1:0] pick_ticks();
        logic [63:0] freq;
        freq = (stamps.tick_freq == '0) ? 64'd1 : {32'd0, stamps.tick_freq};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return {$urandom, $urandom};
            // just around the reference instant, either side
            4, 5:       return stamps.base_ticks + 64'($urandom_range(0, 2000)) - 64'd1000;
            // a believable uptime: whole seconds plus some sub-second ticks
            6, 7:       return stamps.base_ticks + freq * 64'($urandom_range(0, 5000))
                               + (64'($urandom) % freq);
            // counter behind base, elapsed wraps to near 2^64
            8:          return stamps.base_ticks - 64'($urandom_range(1, 1000));
            default:    return $urandom_range(0, 1) ? '0 : '1;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [TICK_W-1:0] base;
        logic [SECS_W-1:0] secs;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        tick_ch.valid     = 1'b0;
        tick_ch.now_ticks = '0;
        send_idle_pct     = 34;
        recv_idle_pct     = 48;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values: base 0, 1 MHz, unix seconds 0
        send_tick('0);
        send_tick(64'd999999);
        send_tick(64'd1000000);
        send_tick('1);
        drain_stamps();

        // 1 Hz with everything at its top: seconds sum overflows
        load_config('1, 32'd1, '1);
        send_tick('0);
        send_tick('1);
        send_tick(64'hFFFF_FFFF_FFFF_FFFE);
        drain_stamps();

        // zero frequency, and a counter that sits behind the base
        load_config(64'd100, '0, 32'h8000_0000);
        send_tick(64'd99);
        send_tick(64'd100);
        send_tick(64'd101);
        send_tick('1);
        drain_stamps();

        // widest divisor, remainders just under it
        load_config('0, '1, '0);
        send_tick('1);
        send_tick(64'h0000_0000_FFFF_FFFE);
        send_tick(64'h0000_0000_FFFF_FFFF);
        send_tick(64'hFFFF_FFFE_0000_0001);
        drain_stamps();

        load_config(64'd1, 32'd32768, 32'h8000_0000);
        send_tick(64'd1);
        send_tick(64'd32769);
        send_tick('0);
        drain_stamps();

        // random settings; idling moves from sender-light to receiver-light,
        // then both sides run flat out
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase < 3)
            begin
                send_idle_pct = 34;
                recv_idle_pct = 48;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 34;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case ($urandom_range(0, 3))
                0:       base = '0;
                1:       base = '1;
                default: base = {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 3))
                0:       secs = '0;
                1:       secs = '1;
                default: secs = $urandom;
            endcase
            load_config(base, pick_freq(), secs);

            for (int n = 0; n < REQS_PER_PHASE; n++)
            begin
                // now and then the sender waits for the pipeline to empty
                if ((phase == 0 && n == 70) || $urandom_range(0, 149) == 0)
                    drain_stamps();
                send_tick(pick_ticks());
            end
            drain_stamps();
        end

        // quiet tail so that a stray extra stamp is still caught
        repeat (DRAIN_TAIL) @(negedge clk);

        $display("converted %0d tick counts, %0d stamps checked, over %0d register settings",
                 stamps.requests_seen, stamps.stamps_checked, RANDOM_PHASES + 5);
        $display("zero and 1 Hz frequencies, base wrap, seconds overflow and stray index seen");
        if (stamps.mismatches == 0 && stamps.pending() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legitimate run
    initial
    begin
        #2000000;
        $display("timeout with %0d stamps outstanding", stamps.pending());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
